// ===== design/program_stream_pes_parser_assert.svh =====
// Assertion macros for the parser checker.
`ifndef PROGRAM_STREAM_PES_PARSER_ASSERT_SVH
`define PROGRAM_STREAM_PES_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSP_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PSP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psp assertion failed");

`endif

// ===== design/psp_pkg.sv =====
package psp_pkg;

  localparam int unsigned TimeW = 33;

  typedef enum logic [5:0] {
    PH_SC1       = 6'd0,
    PH_SC2       = 6'd1,
    PH_SC3       = 6'd2,
    PH_SC4       = 6'd3,
    PH_PACK1     = 6'd4,
    PH_PACK2     = 6'd5,
    PH_PACK3     = 6'd6,
    PH_PACK4     = 6'd7,
    PH_PACK5     = 6'd8,
    PH_PACK6     = 6'd9,
    PH_PACK7     = 6'd10,
    PH_PACK8     = 6'd11,
    PH_PACK9     = 6'd12,
    PH_PACK10    = 6'd13,
    PH_PACK_SKIP = 6'd14,
    PH_SYS1      = 6'd15,
    PH_SYS2      = 6'd16,
    PH_SYS_SKIP  = 6'd17,
    PH_LEN1      = 6'd18,
    PH_LEN2      = 6'd19,
    PH_EXT1      = 6'd20,
    PH_EXT2      = 6'd21,
    PH_EXT3      = 6'd22,
    PH_PTS1      = 6'd23,
    PH_PTS2      = 6'd24,
    PH_PTS3      = 6'd25,
    PH_PTS4      = 6'd26,
    PH_PTS5      = 6'd27,
    PH_DTS1      = 6'd28,
    PH_DTS2      = 6'd29,
    PH_DTS3      = 6'd30,
    PH_DTS4      = 6'd31,
    PH_DTS5      = 6'd32,
    PH_HDR_DATA  = 6'd33,
    PH_PAYLOAD   = 6'd34
  } phase_e;

  localparam logic [1:0] KIND_HDR = 2'd0;
  localparam logic [1:0] KIND_PAY = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  localparam logic [7:0] ID_PACK  = 8'hBA;
  localparam logic [7:0] ID_SYS   = 8'hBB;
  localparam logic [7:0] ID_END   = 8'hB9;
  localparam logic [7:0] ID_PSM   = 8'hBC;
  localparam logic [7:0] ID_PAD   = 8'hBE;
  localparam logic [7:0] ID_PRIV2 = 8'hBF;
  localparam logic [7:0] ID_ECM   = 8'hF0;
  localparam logic [7:0] ID_EMM   = 8'hF1;
  localparam logic [7:0] ID_DSMCC = 8'hF2;
  localparam logic [7:0] ID_H222E = 8'hF8;
  localparam logic [7:0] ID_DIR   = 8'hFF;

  localparam int unsigned FlagPtsBit   = 7;
  localparam int unsigned FlagDtsBit   = 6;
  localparam int unsigned FlagAlignBit = 2;
  localparam logic [7:0]  TimeFirstMask = 8'h0E;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       stream;
    logic [7:0]       pay;
    logic             pend;
    logic             sstart;
    logic             key;
    logic [TimeW-1:0] pts;
    logic [TimeW-1:0] dts;
    logic             meta;
    logic [15:0]      prog;
  } res_t;

  function automatic logic has_ext(input logic [7:0] id);
    return id != ID_PSM && id != ID_PAD && id != ID_PRIV2 && id != ID_ECM &&
           id != ID_DSMCC && id != ID_H222E && id != ID_DIR;
  endfunction

  function automatic logic is_elem(input logic [7:0] id);
    return id != ID_PSM && id != ID_PAD && id != ID_PRIV2 && id != ID_ECM;
  endfunction

  function automatic logic is_media(input logic [7:0] id);
    return id != ID_PSM && id != ID_PRIV2 && id != ID_ECM && id != ID_EMM &&
           id != ID_PAD;
  endfunction

  // One byte of a 5-byte PTS/DTS field; marker bits are dropped or overlaid.
  function automatic logic [TimeW-1:0] time_byte(input logic [2:0]       pos,
                                                 input logic [7:0]       b,
                                                 input logic [TimeW-1:0] acc);
    logic [TimeW-1:0] r;
    r = '0;
    unique case (pos)
      3'd0:    r = {{(TimeW-8){1'b0}}, b & TimeFirstMask};
      3'd1:    r = {acc[TimeW-8:0], 7'd0} | {{(TimeW-8){1'b0}}, b};
      3'd3:    r = {acc[TimeW-9:0], b};
      default: r = {acc[TimeW-8:0], b[7:1]};
    endcase
    return r;
  endfunction

endpackage

// ===== design/psp_core.sv =====
module psp_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    in_byte_i,
  output psp_pkg::res_t res_o
);
  import psp_pkg::*;

  phase_e           ph_q, ph_d;
  logic [15:0]      sk_q, sk_d;
  logic [7:0]       cs_q, cs_d;
  logic [15:0]      pl_q, pl_d;
  logic [7:0]       f1_q, f1_d;
  logic [7:0]       f2_q, f2_d;
  logic [7:0]       hd_q, hd_d;
  logic [TimeW-1:0] acc_q, acc_d;
  logic [TimeW-1:0] pts_q, pts_d;
  logic [TimeW-1:0] dts_q, dts_d;
  logic             meta_q, meta_d;
  logic             sp_q, sp_d;
  logic [15:0]      prog_q, prog_d;

  logic [15:0] pl_dec, sk_dec;
  logic [7:0]  hd_dec;
  logic [5:0]  ph_inc;
  logic        do_enter, do_after;
  logic [1:0]  kind;
  logic [7:0]  pay;
  logic        pend, sstart;

  assign pl_dec = (pl_q != 16'd0) ? pl_q - 16'd1 : pl_q;
  assign hd_dec = (hd_q != 8'd0) ? hd_q - 8'd1 : hd_q;
  assign sk_dec = (sk_q != 16'd0) ? sk_q - 16'd1 : sk_q;
  assign ph_inc = 6'(ph_q) + 6'd1;

  always_comb begin
    ph_d     = ph_q;
    sk_d     = sk_q;
    cs_d     = cs_q;
    pl_d     = pl_q;
    f1_d     = f1_q;
    f2_d     = f2_q;
    hd_d     = hd_q;
    acc_d    = acc_q;
    pts_d    = pts_q;
    dts_d    = dts_q;
    meta_d   = meta_q;
    sp_d     = sp_q;
    prog_d   = prog_q;
    do_enter = 1'b0;
    do_after = 1'b0;
    kind     = KIND_HDR;
    pay      = 8'd0;
    pend     = 1'b0;
    sstart   = 1'b0;

    unique case (ph_q)
      PH_SC1: begin
        if (in_byte_i == 8'h00) ph_d = PH_SC2;
      end
      PH_SC2: begin
        ph_d = (in_byte_i == 8'h00) ? PH_SC3 : PH_SC1;
      end
      PH_SC3: begin
        if (in_byte_i == 8'h01) ph_d = PH_SC4;
        else if (in_byte_i != 8'h00) ph_d = PH_SC1;
      end
      PH_SC4: begin
        if (in_byte_i == ID_PACK) begin
          ph_d = PH_PACK1;
        end else if (in_byte_i == ID_SYS) begin
          ph_d = PH_SYS1;
        end else if (in_byte_i == ID_END) begin
          kind   = KIND_END;
          meta_d = 1'b1;
          pts_d  = '0;
          dts_d  = '0;
          prog_d = prog_q + 16'd1;
          sp_d   = 1'b0;
          ph_d   = PH_SC1;
        end else begin
          cs_d = in_byte_i;
          if (is_media(in_byte_i)) meta_d = 1'b1;
          ph_d = PH_LEN1;
        end
      end
      PH_PACK1, PH_PACK2, PH_PACK3, PH_PACK4, PH_PACK5,
      PH_PACK6, PH_PACK7, PH_PACK8, PH_PACK9: begin
        ph_d = phase_e'(ph_inc);
      end
      PH_PACK10: begin
        sk_d = {13'd0, in_byte_i[2:0]};
        ph_d = (in_byte_i[2:0] == 3'd0) ? PH_SC1 : PH_PACK_SKIP;
      end
      PH_SYS1: begin
        sk_d = {in_byte_i, 8'd0};
        ph_d = PH_SYS2;
      end
      PH_SYS2: begin
        sk_d = {sk_q[15:8], in_byte_i};
        ph_d = (sk_d == 16'd0) ? PH_SC1 : PH_SYS_SKIP;
      end
      PH_PACK_SKIP, PH_SYS_SKIP: begin
        sk_d = sk_dec;
        if (sk_dec == 16'd0) ph_d = PH_SC1;
      end
      PH_LEN1: begin
        pl_d = {in_byte_i, 8'd0};
        ph_d = PH_LEN2;
      end
      PH_LEN2: begin
        pl_d = {pl_q[15:8], in_byte_i};
        if (has_ext(cs_q)) begin
          ph_d = PH_EXT1;
        end else begin
          f1_d     = '0;
          f2_d     = '0;
          hd_d     = '0;
          do_enter = 1'b1;
        end
      end
      PH_EXT1: begin
        f1_d = in_byte_i;
        pl_d = pl_dec;
        ph_d = PH_EXT2;
      end
      PH_EXT2: begin
        f2_d = in_byte_i;
        pl_d = pl_dec;
        ph_d = PH_EXT3;
      end
      PH_EXT3: begin
        hd_d = in_byte_i;
        pl_d = pl_dec;
        if (f2_q[FlagPtsBit]) ph_d = PH_PTS1;
        else do_after = 1'b1;
      end
      PH_PTS1, PH_PTS2, PH_PTS3, PH_PTS4, PH_PTS5: begin
        acc_d = time_byte(3'(6'(ph_q) - 6'(PH_PTS1)), in_byte_i, acc_q);
        pl_d  = pl_dec;
        hd_d  = hd_dec;
        if (ph_q == PH_PTS5) begin
          pts_d = acc_d;
          if (f2_q[FlagDtsBit]) begin
            ph_d = PH_DTS1;
          end else begin
            dts_d    = acc_d;
            do_after = 1'b1;
          end
        end else begin
          ph_d = phase_e'(ph_inc);
        end
      end
      PH_DTS1, PH_DTS2, PH_DTS3, PH_DTS4, PH_DTS5: begin
        acc_d = time_byte(3'(6'(ph_q) - 6'(PH_DTS1)), in_byte_i, acc_q);
        pl_d  = pl_dec;
        hd_d  = hd_dec;
        if (ph_q == PH_DTS5) begin
          dts_d    = acc_d;
          do_after = 1'b1;
        end else begin
          ph_d = phase_e'(ph_inc);
        end
      end
      PH_HDR_DATA: begin
        pl_d = pl_dec;
        hd_d = hd_dec;
        if (hd_dec == 8'd0) do_enter = 1'b1;
      end
      PH_PAYLOAD: begin
        kind   = KIND_PAY;
        pay    = in_byte_i;
        sstart = sp_q;
        sp_d   = 1'b0;
        pl_d   = pl_dec;
        if (pl_dec == 16'd0) begin
          pend = 1'b1;
          ph_d = PH_SC1;
        end
      end
      default: ph_d = PH_SC1;
    endcase

    // end of PES header: remaining header data, payload, or back to search
    if (do_after && hd_d != 8'd0) begin
      ph_d = PH_HDR_DATA;
    end else if (do_after || do_enter) begin
      if (pl_d == 16'd0) begin
        ph_d = PH_SC1;
        sp_d = 1'b0;
      end else begin
        ph_d = PH_PAYLOAD;
        sp_d = is_elem(cs_d) && f2_d[FlagPtsBit];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_SC1;
      sk_q   <= '0;
      cs_q   <= '0;
      pl_q   <= '0;
      f1_q   <= '0;
      f2_q   <= '0;
      hd_q   <= '0;
      acc_q  <= '0;
      pts_q  <= '0;
      dts_q  <= '0;
      meta_q <= 1'b0;
      sp_q   <= 1'b0;
      prog_q <= '0;
    end else if (step_i) begin
      ph_q   <= ph_d;
      sk_q   <= sk_d;
      cs_q   <= cs_d;
      pl_q   <= pl_d;
      f1_q   <= f1_d;
      f2_q   <= f2_d;
      hd_q   <= hd_d;
      acc_q  <= acc_d;
      pts_q  <= pts_d;
      dts_q  <= dts_d;
      meta_q <= meta_d;
      sp_q   <= sp_d;
      prog_q <= prog_d;
    end
  end

  always_comb begin
    res_o.kind   = kind;
    res_o.stream = cs_d;
    res_o.pay    = pay;
    res_o.pend   = pend;
    res_o.sstart = sstart;
    res_o.key    = f1_d[FlagAlignBit];
    res_o.pts    = pts_d;
    res_o.dts    = dts_d;
    res_o.meta   = meta_d;
    res_o.prog   = prog_d;
  end

endmodule

// ===== design/program_stream_pes_parser.sv =====
// MPEG-2 program stream PES demultiplexer. One byte of stream enters per cycle
// while in_stall_o is low and yields exactly one result transaction: a
// header/skipped byte, a payload byte tagged with its stream id, packet-end and
// sample-start marks, or a program-end event, always with the current PTS/DTS,
// key-frame bit, metadata flag and program count. The byte's parse step is
// combinational logic on the parser state; its result lands in an output
// register and appears in the cycle after the input transaction. Throughput is
// one byte per clock while not stalled; in_stall_o rises only while a finished
// result sits in the output register and the downstream side is stalling it.
module program_stream_pes_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  byte_kind_o,
  output logic [7:0]  stream_ident_o,
  output logic [7:0]  payload_byte_o,
  output logic        packet_end_o,
  output logic        sample_start_o,
  output logic        key_frame_o,
  output logic [32:0] present_time_o,
  output logic [32:0] decode_time_o,
  output logic        metadata_done_o,
  output logic [15:0] program_index_o
);
  import psp_pkg::*;

  logic in_acc;
  res_t res_d, res_q;
  logic vld_q;

  assign in_stall_o = vld_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  psp_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (in_acc),
    .in_byte_i (in_byte_i),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = vld_q;
  assign byte_kind_o     = res_q.kind;
  assign stream_ident_o  = res_q.stream;
  assign payload_byte_o  = res_q.pay;
  assign packet_end_o    = res_q.pend;
  assign sample_start_o  = res_q.sstart;
  assign key_frame_o     = res_q.key;
  assign present_time_o  = res_q.pts;
  assign decode_time_o   = res_q.dts;
  assign metadata_done_o = res_q.meta;
  assign program_index_o = res_q.prog;

endmodule

// ===== design/psp_checker.sv =====
`include "program_stream_pes_parser_assert.svh"

module psp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  byte_kind_o,
  input logic [7:0]  payload_byte_o,
  input logic        packet_end_o,
  input logic        sample_start_o,
  input logic [32:0] present_time_o,
  input logic [32:0] decode_time_o,
  input logic        metadata_done_o
);
  import psp_pkg::*;

  logic        nonpay_vld;
  logic        mark_vld;
  logic        end_vld;
  logic        end_ok;
  logic        out_held;
  logic [40:0] held_bits;

  assign nonpay_vld = out_valid_o && byte_kind_o != KIND_PAY;
  assign mark_vld   = out_valid_o && (packet_end_o || sample_start_o);
  assign end_vld    = out_valid_o && byte_kind_o == KIND_END;
  assign end_ok     = metadata_done_o && present_time_o == 33'd0 && decode_time_o == 33'd0;
  assign out_held   = out_valid_o && out_stall_i;
  assign held_bits  = {payload_byte_o, present_time_o};

  `PSP_ASSERT_IMP(a_nonpay_zero, clk_i, rst_ni, nonpay_vld, payload_byte_o == 8'd0)
  `PSP_ASSERT_IMP(a_marks_on_pay, clk_i, rst_ni, mark_vld, byte_kind_o == KIND_PAY)
  `PSP_ASSERT_IMP(a_end_clears, clk_i, rst_ni, end_vld, end_ok)
  `PSP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(held_bits))

endmodule

bind program_stream_pes_parser psp_checker u_psp_checker (.*);

// ===== dv/tb_program_stream_pes_parser.sv =====
module tb_program_stream_pes_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import psp_pkg::*;

  localparam int unsigned DirRows    = 26;
  localparam int unsigned RandItems  = 600;
  localparam int unsigned QuietTail  = 100;
  localparam int unsigned LongHoldAt = 150;
  localparam int unsigned LongHold   = 80;

  typedef struct packed {
    logic [7:0]  val;
    logic        typed;
    logic [1:0]  kind;
    logic [7:0]  pay;
    logic [15:0] prog;
  } stim_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  in_byte_i   = 8'h00;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  byte_kind_o;
  logic [7:0]  stream_ident_o;
  logic [7:0]  payload_byte_o;
  logic        packet_end_o;
  logic        sample_start_o;
  logic        key_frame_o;
  logic [32:0] present_time_o;
  logic [32:0] decode_time_o;
  logic        metadata_done_o;
  logic [15:0] program_index_o;

  program_stream_pes_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_byte_i       (in_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .byte_kind_o     (byte_kind_o),
    .stream_ident_o  (stream_ident_o),
    .payload_byte_o  (payload_byte_o),
    .packet_end_o    (packet_end_o),
    .sample_start_o  (sample_start_o),
    .key_frame_o     (key_frame_o),
    .present_time_o  (present_time_o),
    .decode_time_o   (decode_time_o),
    .metadata_done_o (metadata_done_o),
    .program_index_o (program_index_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  stim_row_t   dir_tab [DirRows];
  stim_row_t   byte_feed [$];
  res_t        due_results [$];
  int unsigned fed = 0;
  int unsigned noise_items = 0;
  int unsigned errors = 0;

  // Demux state mirror
  phase_e      phase_q    = PH_SC1;
  logic [15:0] skip_cnt   = '0;
  logic [7:0]  sid        = '0;
  logic [15:0] pkt_left   = '0;
  logic [7:0]  flags1     = '0;
  logic [7:0]  flags2     = '0;
  logic [7:0]  hdr_left   = '0;
  logic [32:0] ts_acc     = '0;
  logic [32:0] pts_q      = '0;
  logic [32:0] dts_q      = '0;
  logic        meta_q     = 1'b0;
  logic        sample_due = 1'b0;
  logic [15:0] prog_cnt   = '0;

  function automatic bit carries_ext(input logic [7:0] id);
    return !(id inside {ID_PSM, ID_PAD, ID_PRIV2, ID_ECM, ID_DSMCC, ID_H222E, ID_DIR});
  endfunction

  task automatic start_payload();
    if (pkt_left == 16'd0) begin
      phase_q    = PH_SC1;
      sample_due = 1'b0;
    end else begin
      phase_q    = PH_PAYLOAD;
      sample_due = !(sid inside {ID_PSM, ID_PAD, ID_PRIV2, ID_ECM}) && flags2[FlagPtsBit];
    end
  endtask

  task automatic finish_header();
    if (hdr_left == 8'd0) start_payload();
    else phase_q = PH_HDR_DATA;
  endtask

  task automatic drop_header_byte();
    if (pkt_left != 16'd0) pkt_left--;
    if (hdr_left != 8'd0) hdr_left--;
  endtask

  task automatic demux_byte(input logic [7:0] b, output res_t r);
    logic [1:0] kind;
    logic [7:0] pay;
    logic       pend;
    logic       sst;
    logic [2:0] pos;
    kind = KIND_HDR;
    pay  = 8'h00;
    pend = 1'b0;
    sst  = 1'b0;
    case (phase_q)
      PH_SC1: if (b == 8'h00) phase_q = PH_SC2;
      PH_SC2: phase_q = (b == 8'h00) ? PH_SC3 : PH_SC1;
      PH_SC3: begin
        if (b == 8'h01) phase_q = PH_SC4;
        else if (b != 8'h00) phase_q = PH_SC1;
      end
      PH_SC4: begin
        if (b == ID_PACK) begin
          phase_q = PH_PACK1;
        end else if (b == ID_SYS) begin
          phase_q = PH_SYS1;
        end else if (b == ID_END) begin
          kind       = KIND_END;
          meta_q     = 1'b1;
          pts_q      = '0;
          dts_q      = '0;
          prog_cnt   = prog_cnt + 16'd1;
          sample_due = 1'b0;
          phase_q    = PH_SC1;
        end else begin
          sid = b;
          if (!(b inside {ID_PSM, ID_PRIV2, ID_ECM, ID_EMM, ID_PAD})) meta_q = 1'b1;
          phase_q = PH_LEN1;
        end
      end
      PH_PACK1, PH_PACK2, PH_PACK3, PH_PACK4, PH_PACK5,
      PH_PACK6, PH_PACK7, PH_PACK8, PH_PACK9: phase_q = phase_e'(phase_q + 6'd1);
      PH_PACK10: begin
        skip_cnt = {13'd0, b[2:0]};
        phase_q  = (b[2:0] == 3'd0) ? PH_SC1 : PH_PACK_SKIP;
      end
      PH_SYS1: begin
        skip_cnt = {b, 8'h00};
        phase_q  = PH_SYS2;
      end
      PH_SYS2: begin
        skip_cnt[7:0] = b;
        phase_q = (skip_cnt == 16'd0) ? PH_SC1 : PH_SYS_SKIP;
      end
      PH_PACK_SKIP, PH_SYS_SKIP: begin
        if (skip_cnt != 16'd0) skip_cnt--;
        if (skip_cnt == 16'd0) phase_q = PH_SC1;
      end
      PH_LEN1: begin
        pkt_left = {b, 8'h00};
        phase_q  = PH_LEN2;
      end
      PH_LEN2: begin
        pkt_left[7:0] = b;
        if (carries_ext(sid)) begin
          phase_q = PH_EXT1;
        end else begin
          flags1   = '0;
          flags2   = '0;
          hdr_left = '0;
          start_payload();
        end
      end
      PH_EXT1: begin
        flags1 = b;
        if (pkt_left != 16'd0) pkt_left--;
        phase_q = PH_EXT2;
      end
      PH_EXT2: begin
        flags2 = b;
        if (pkt_left != 16'd0) pkt_left--;
        phase_q = PH_EXT3;
      end
      PH_EXT3: begin
        hdr_left = b;
        if (pkt_left != 16'd0) pkt_left--;
        if (flags2[FlagPtsBit]) phase_q = PH_PTS1;
        else finish_header();
      end
      PH_PTS1, PH_PTS2, PH_PTS3, PH_PTS4, PH_PTS5,
      PH_DTS1, PH_DTS2, PH_DTS3, PH_DTS4, PH_DTS5: begin
        pos = (phase_q >= PH_DTS1) ? 3'(phase_q - PH_DTS1) : 3'(phase_q - PH_PTS1);
        case (pos)
          3'd0:    ts_acc = {25'd0, b & TimeFirstMask};
          3'd1:    ts_acc = {ts_acc[25:0], 7'd0} | {25'd0, b};
          3'd3:    ts_acc = {ts_acc[24:0], b};
          default: ts_acc = {ts_acc[25:0], b[7:1]};
        endcase
        drop_header_byte();
        if (phase_q == PH_PTS5) begin
          pts_q = ts_acc;
          if (flags2[FlagDtsBit]) begin
            phase_q = PH_DTS1;
          end else begin
            dts_q = ts_acc;
            finish_header();
          end
        end else if (phase_q == PH_DTS5) begin
          dts_q = ts_acc;
          finish_header();
        end else begin
          phase_q = phase_e'(phase_q + 6'd1);
        end
      end
      PH_HDR_DATA: begin
        drop_header_byte();
        if (hdr_left == 8'd0) start_payload();
      end
      PH_PAYLOAD: begin
        kind       = KIND_PAY;
        pay        = b;
        sst        = sample_due;
        sample_due = 1'b0;
        if (pkt_left != 16'd0) pkt_left--;
        if (pkt_left == 16'd0) begin
          pend    = 1'b1;
          phase_q = PH_SC1;
        end
      end
      default: phase_q = PH_SC1;
    endcase
    r.kind   = kind;
    r.stream = sid;
    r.pay    = pay;
    r.pend   = pend;
    r.sstart = sst;
    r.key    = flags1[FlagAlignBit];
    r.pts    = pts_q;
    r.dts    = dts_q;
    r.meta   = meta_q;
    r.prog   = prog_cnt;
  endtask

  // Stream generation
  task automatic put_byte(input logic [7:0] b);
    stim_row_t row;
    row = '{val: b, typed: 1'b0, kind: KIND_HDR, pay: 8'h00, prog: 16'h0000};
    byte_feed = {byte_feed, row};
  endtask

  task automatic put_start_code();
    int unsigned extra;
    extra = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
    repeat (extra + 2) put_byte(8'h00);
    put_byte(8'h01);
  endtask

  task automatic put_pack();
    logic [7:0] stuff;
    put_start_code();
    put_byte(ID_PACK);
    repeat (9) put_byte(8'($urandom));
    stuff = 8'($urandom);
    put_byte(stuff);
    repeat (stuff[2:0]) put_byte(8'($urandom));
  endtask

  task automatic put_sys_header();
    logic [15:0] len;
    len = 16'($urandom_range(0, 8));
    put_start_code();
    put_byte(ID_SYS);
    put_byte(len[15:8]);
    put_byte(len[7:0]);
    repeat (len) put_byte(8'($urandom));
  endtask

  task automatic put_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 6)) begin
      b = 8'($urandom);
      if (b == 8'h01) b = 8'h02;
      put_byte(b);
      noise_items++;
    end
  endtask

  // broken: declared length unrelated to the bytes that follow
  task automatic put_pes(input bit broken);
    logic [7:0]  id;
    logic [7:0]  f2;
    logic [15:0] plen;
    int unsigned n_ts;
    int unsigned hlen;
    int unsigned extra;
    int unsigned hdr_bytes;
    int unsigned n_pay;
    case ($urandom_range(0, 5))
      0: id = 8'hE0 | 8'($urandom_range(0, 15));
      1: id = 8'hC0 | 8'($urandom_range(0, 31));
      2: id = 8'hBD;
      3: begin
        case ($urandom_range(0, 7))
          0: id = ID_PSM;
          1: id = ID_PAD;
          2: id = ID_PRIV2;
          3: id = ID_ECM;
          4: id = ID_EMM;
          5: id = ID_DSMCC;
          6: id = ID_H222E;
          default: id = ID_DIR;
        endcase
      end
      default: begin
        id = 8'($urandom);
        if (id inside {ID_PACK, ID_SYS, ID_END}) id = 8'hBD;
      end
    endcase
    n_pay = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    f2 = 8'h00;
    n_ts = 0;
    hlen = 0;
    extra = 0;
    hdr_bytes = 0;
    if (carries_ext(id)) begin
      f2 = {2'($urandom_range(0, 3)), 6'($urandom)};
      n_ts = f2[7] ? (f2[6] ? 10 : 5) : 0;
      hlen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n_ts)
                                         : n_ts + $urandom_range(0, 3);
      extra = (hlen > n_ts) ? hlen - n_ts : 0;
      hdr_bytes = 3 + n_ts + extra;
    end
    plen = 16'(hdr_bytes + n_pay);
    if (hdr_bytes != 0 && $urandom_range(0, 7) == 0) begin
      plen  = 16'($urandom_range(0, hdr_bytes));
      n_pay = (plen > hdr_bytes) ? plen - hdr_bytes : 0;
    end
    if (broken) begin
      plen  = 16'($urandom_range(0, 30));
      n_pay = $urandom_range(0, 10);
    end
    put_start_code();
    put_byte(id);
    put_byte(plen[15:8]);
    put_byte(plen[7:0]);
    if (hdr_bytes != 0) begin
      put_byte(8'($urandom));
      put_byte(f2);
      put_byte(8'(hlen));
      repeat (n_ts + extra) put_byte(8'($urandom));
    end
    repeat (n_pay) put_byte(8'($urandom));
  endtask

  task automatic cmp_field(input string name, input logic [32:0] want, input logic [32:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, seen);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual kind %0h byte %0h", $time,
                 byte_kind_o, payload_byte_o);
        errors++;
      end else begin
        want = due_results[0];
        due_results.delete(0);
        cmp_field("byte_kind", want.kind, byte_kind_o);
        cmp_field("stream_ident", want.stream, stream_ident_o);
        cmp_field("payload_byte", want.pay, payload_byte_o);
        cmp_field("packet_end", want.pend, packet_end_o);
        cmp_field("sample_start", want.sstart, sample_start_o);
        cmp_field("key_frame", want.key, key_frame_o);
        cmp_field("present_time", want.pts, present_time_o);
        cmp_field("decode_time", want.dts, decode_time_o);
        cmp_field("metadata_done", want.meta, metadata_done_o);
        cmp_field("program_index", want.prog, program_index_o);
      end
    end
  end

  initial begin : feeder
    res_t        r;
    int unsigned gap_left;
    gap_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!(in_valid_i && in_stall_o)) begin
        if (in_valid_i) begin
          demux_byte(byte_feed[fed].val, r);
          if (byte_feed[fed].typed) begin
            r.kind = byte_feed[fed].kind;
            r.pay  = byte_feed[fed].pay;
            r.prog = byte_feed[fed].prog;
          end
          due_results = {due_results, r};
          fed++;
        end
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (fed < byte_feed.size()) begin
          in_valid_i <= 1'b1;
          in_byte_i  <= byte_feed[fed].val;
          if (fed + QuietTail < byte_feed.size() && $urandom_range(0, 7) == 0)
            gap_left = $urandom_range(1, 19);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  initial begin : drain
    int unsigned stall_left;
    int unsigned run_left;
    bit          held;
    stall_left = 0;
    run_left   = 0;
    held       = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!held && fed >= LongHoldAt) begin
        held       = 1'b1;
        stall_left = LongHold;
      end else if (stall_left == 0 && run_left == 0 && fed + QuietTail < byte_feed.size()) begin
        if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 19);
        else run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (run_left != 0) run_left--;
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : main
    int unsigned pick;
    dir_tab = '{
      '{8'h00, 1'b1, KIND_HDR, 8'h00, 16'd0},
      '{8'h00, 1'b0, KIND_HDR, 8'h00, 16'd0},
      '{8'h00, 1'b0, KIND_HDR, 8'h00, 16'd0},
      '{8'h01, 1'b0, KIND_HDR, 8'h00, 16'd0},
      '{ID_END, 1'b1, KIND_END, 8'h00, 16'd1},
      '{8'h00, 1'b0, KIND_HDR, 8'h00, 16'd0},
      '{8'h00, 1'b0, KIND_HDR, 8'h00, 16'd0},
      '{8'h01, 1'b0, KIND_HDR, 8'h00, 16'd0},
      '{ID_PAD, 1'b0, KIND_HDR, 8'h00, 16'd0},
      '{8'h00, 1'b0, KIND_HDR, 8'h00, 16'd0},
      '{8'h01, 1'b0, KIND_HDR, 8'h00, 16'd0},
      '{8'hFF, 1'b1, KIND_PAY, 8'hFF, 16'd1},
      '{8'h00, 1'b0, KIND_HDR, 8'h00, 16'd0},
      '{8'h00, 1'b0, KIND_HDR, 8'h00, 16'd0},
      '{8'h01, 1'b0, KIND_HDR, 8'h00, 16'd0},
      '{8'hE0, 1'b0, KIND_HDR, 8'h00, 16'd0},
      '{8'h00, 1'b0, KIND_HDR, 8'h00, 16'd0},
      '{8'h00, 1'b0, KIND_HDR, 8'h00, 16'd0},
      '{8'h84, 1'b0, KIND_HDR, 8'h00, 16'd0},
      '{8'h80, 1'b0, KIND_HDR, 8'h00, 16'd0},
      '{8'h05, 1'b0, KIND_HDR, 8'h00, 16'd0},
      '{8'hFF, 1'b0, KIND_HDR, 8'h00, 16'd0},
      '{8'hFF, 1'b0, KIND_HDR, 8'h00, 16'd0},
      '{8'hFF, 1'b0, KIND_HDR, 8'h00, 16'd0},
      '{8'hFF, 1'b0, KIND_HDR, 8'h00, 16'd0},
      '{8'hFF, 1'b0, KIND_HDR, 8'h00, 16'd0}
    };
    foreach (dir_tab[i]) byte_feed = {byte_feed, dir_tab[i]};
    while (byte_feed.size() - noise_items < DirRows + RandItems) begin
      pick = $urandom_range(0, 19);
      if (pick < 10) put_pes(1'b0);
      else if (pick < 13) put_pack();
      else if (pick < 15) put_sys_header();
      else if (pick < 16) begin
        put_start_code();
        put_byte(ID_END);
      end else if (pick < 18) put_noise();
      else put_pes(1'b1);
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (fed < byte_feed.size() || due_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("tb_program_stream_pes_parser: clean");
    else $display("tb_program_stream_pes_parser: errors");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb_program_stream_pes_parser: errors");
    $finish;
  end

endmodule
